/* src/assert_macros.svh */
// Assertion helpers used by the checker file piq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle, ignored while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// a implies b in the next cycle, ignored while reset is high
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

// a implies b in the next cycle, checked during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

/* src/piq_pkg.sv */
`default_nettype none
package piq_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 16;

   // op codes of a query item
   localparam logic OP_TRIANGLE   = 1'b0;
   localparam logic OP_QUADRANGLE = 1'b1;

   // sign of the two components of a direction vector
   typedef struct packed {
      logic x_pos;
      logic x_neg;
      logic y_pos;
      logic y_neg;
   } dir_flags_type;

   // true when two vectors point the same way in x or in y
   function automatic logic same_way(dir_flags_type u, dir_flags_type v);
      return (u.x_pos & v.x_pos) | (u.x_neg & v.x_neg) |
             (u.y_pos & v.y_pos) | (u.y_neg & v.y_neg);
   endfunction

endpackage
`default_nettype wire

/* src/piq_if.sv */
`default_nettype none
// query channel
interface piq_req_if #(parameter int COORD_BITS = piq_pkg::COORD_BITS_DEFAULT);
   import piq_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COORD_BITS-1:0] vx0;
   logic signed [COORD_BITS-1:0] vy0;
   logic signed [COORD_BITS-1:0] vx1;
   logic signed [COORD_BITS-1:0] vy1;
   logic signed [COORD_BITS-1:0] vx2;
   logic signed [COORD_BITS-1:0] vy2;
   logic signed [COORD_BITS-1:0] vx3;
   logic signed [COORD_BITS-1:0] vy3;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, op, vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3,
                   point_x, point_y, input ready);
   modport sink   (input valid, op, vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3,
                   point_x, point_y, output ready);
endinterface

// result channel
interface piq_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface
`default_nettype wire

/* src/piq_tri_products.sv */
`default_nettype none
// Partial products of the edge cross products (edges ab, bc, ca) of a triangle,
// registered, plus the sign flags of its direction vectors a, b and c.
module piq_tri_products #(
   parameter int COORD_BITS = piq_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic signed [COORD_BITS:0]     ax,
   input  wire logic signed [COORD_BITS:0]     ay,
   input  wire logic signed [COORD_BITS:0]     bx,
   input  wire logic signed [COORD_BITS:0]     by,
   input  wire logic signed [COORD_BITS:0]     cx,
   input  wire logic signed [COORD_BITS:0]     cy,
   output logic signed [2*COORD_BITS+1:0]      p_ab_xy,
   output logic signed [2*COORD_BITS+1:0]      p_ab_yx,
   output logic signed [2*COORD_BITS+1:0]      p_bc_xy,
   output logic signed [2*COORD_BITS+1:0]      p_bc_yx,
   output logic signed [2*COORD_BITS+1:0]      p_ca_xy,
   output logic signed [2*COORD_BITS+1:0]      p_ca_yx,
   output piq_pkg::dir_flags_type              flags_a,
   output piq_pkg::dir_flags_type              flags_b,
   output piq_pkg::dir_flags_type              flags_c
);
   import piq_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [PW-1:0] p_ab_xy_in, p_ab_yx_in, p_bc_xy_in, p_bc_yx_in;
   logic signed [PW-1:0] p_ca_xy_in, p_ca_yx_in;
   dir_flags_type        flags_a_in, flags_b_in, flags_c_in;

   function automatic dir_flags_type flags_of(logic signed [DW-1:0] x,
                                              logic signed [DW-1:0] y);
      dir_flags_type f;
      f.x_pos = !x[DW-1] && (|x);
      f.x_neg = x[DW-1];
      f.y_pos = !y[DW-1] && (|y);
      f.y_neg = y[DW-1];
      return f;
   endfunction

   // cross(u, v) = u.x*v.y - u.y*v.x, one product pair per edge
   always_comb begin
      p_ab_xy_in = PW'(ax) * PW'(by);
      p_ab_yx_in = PW'(ay) * PW'(bx);
      p_bc_xy_in = PW'(bx) * PW'(cy);
      p_bc_yx_in = PW'(by) * PW'(cx);
      p_ca_xy_in = PW'(cx) * PW'(ay);
      p_ca_yx_in = PW'(cy) * PW'(ax);
      flags_a_in = flags_of(ax, ay);
      flags_b_in = flags_of(bx, by);
      flags_c_in = flags_of(cx, cy);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_ab_xy <= p_ab_xy_in;
         p_ab_yx <= p_ab_yx_in;
         p_bc_xy <= p_bc_xy_in;
         p_bc_yx <= p_bc_yx_in;
         p_ca_xy <= p_ca_xy_in;
         p_ca_yx <= p_ca_yx_in;
         flags_a <= flags_a_in;
         flags_b <= flags_b_in;
         flags_c <= flags_c_in;
      end
   end
endmodule
`default_nettype wire

/* src/piq_tri_decide.sv */
`default_nettype none
// Inside decision for one triangle from its registered partial products.
module piq_tri_decide #(
   parameter int COORD_BITS = piq_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic signed [2*COORD_BITS+1:0] p_ab_xy,
   input  wire logic signed [2*COORD_BITS+1:0] p_ab_yx,
   input  wire logic signed [2*COORD_BITS+1:0] p_bc_xy,
   input  wire logic signed [2*COORD_BITS+1:0] p_bc_yx,
   input  wire logic signed [2*COORD_BITS+1:0] p_ca_xy,
   input  wire logic signed [2*COORD_BITS+1:0] p_ca_yx,
   input  wire piq_pkg::dir_flags_type         flags_a,
   input  wire piq_pkg::dir_flags_type         flags_b,
   input  wire piq_pkg::dir_flags_type         flags_c,
   output logic                                in_tri
);
   import piq_pkg::*;

   localparam int CW = 2 * COORD_BITS + 3;

   logic signed [CW-1:0] c_ab, c_bc, c_ca;
   logic                 z_ab, z_bc, z_ca;
   logic                 pos_ab, pos_bc, pos_ca;
   logic                 check_a, check_b;

   always_comb begin
      c_ab   = CW'(p_ab_xy) - CW'(p_ab_yx);
      c_bc   = CW'(p_bc_xy) - CW'(p_bc_yx);
      c_ca   = CW'(p_ca_xy) - CW'(p_ca_yx);
      z_ab   = (p_ab_xy == p_ab_yx);
      z_bc   = (p_bc_xy == p_bc_yx);
      z_ca   = (p_ca_xy == p_ca_yx);
      pos_ab = !c_ab[CW-1] && !z_ab;
      pos_bc = !c_bc[CW-1] && !z_bc;
      pos_ca = !c_ca[CW-1] && !z_ca;
      // with no zero edge, each check wants exactly one positive term
      check_a = pos_ca ^ !pos_ab;
      check_b = pos_ab ^ !pos_bc;
      // the first collinear edge in walk order decides alone
      if (z_ab) begin
         in_tri = !same_way(flags_a, flags_b);
      end else if (z_bc) begin
         in_tri = !same_way(flags_b, flags_c);
      end else if (z_ca) begin
         in_tri = !same_way(flags_c, flags_a);
      end else begin
         in_tri = check_a & check_b;
      end
   end
endmodule
`default_nettype wire

/* src/point_in_quadrangle_test_core.sv */
`default_nettype none
// Point-in-triangle / point-in-quadrangle test. Each query item carries a
// point and four vertices; op = 0 tests triangle (v0,v1,v2), op = 1 tests
// the quadrangle as the union of triangles (v0,v1,v3) and (v1,v2,v3). All
// math is exact integer. The block is a three-stage pipeline (input register,
// product register, result register): it accepts one item per cycle while
// rsp is not stalled, and each result is offered on rsp from the result
// register once the item has passed the product register. Every stage
// advances whenever the next one is free, which gives one item per cycle;
// the product stage, holding the twelve COORD_BITS+1 square multipliers of
// both triangles, sets the clock period. Stalls on the result side back up
// stage by stage; no item is dropped.
module point_in_quadrangle_test_core #(
   parameter int COORD_BITS = piq_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   piq_req_if.sink    req,
   piq_rsp_if.source  rsp
);
   import piq_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   // pipeline occupancy
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic free1, free2, free3;

   // stage 1 payload
   logic                         op1_ff;
   logic signed [COORD_BITS-1:0] vx_ff [4];
   logic signed [COORD_BITS-1:0] vy_ff [4];
   logic signed [COORD_BITS-1:0] px_ff, py_ff;

   // stage 2 and stage 3 payload
   logic op2_ff;
   logic res_ff, res_in;

   logic signed [DW-1:0] dx [4];
   logic signed [DW-1:0] dy [4];
   logic signed [DW-1:0] t1_cx, t1_cy;

   logic signed [PW-1:0] t1_ab_xy, t1_ab_yx, t1_bc_xy, t1_bc_yx, t1_ca_xy, t1_ca_yx;
   logic signed [PW-1:0] t2_ab_xy, t2_ab_yx, t2_bc_xy, t2_bc_yx, t2_ca_xy, t2_ca_yx;
   dir_flags_type        t1_fa, t1_fb, t1_fc, t2_fa, t2_fb, t2_fc;
   logic                 t1_inside, t2_inside;

   // handshake: a stage is free when empty or when it moves on this cycle
   always_comb begin
      free3 = !v3_ff || rsp.ready;
      free2 = !v2_ff || free3;
      free1 = !v1_ff || free2;
      v1_in = free1 ? req.valid : v1_ff;
      v2_in = free2 ? v1_ff : v2_ff;
      v3_in = free3 ? v2_ff : v3_ff;
   end

   assign req.ready      = free1;
   assign rsp.valid      = v3_ff;
   assign rsp.inside_res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (free1 && req.valid) begin
         op1_ff   <= req.op;
         vx_ff[0] <= req.vx0;
         vy_ff[0] <= req.vy0;
         vx_ff[1] <= req.vx1;
         vy_ff[1] <= req.vy1;
         vx_ff[2] <= req.vx2;
         vy_ff[2] <= req.vy2;
         vx_ff[3] <= req.vx3;
         vy_ff[3] <= req.vy3;
         px_ff    <= req.point_x;
         py_ff    <= req.point_y;
      end
   end

   // direction vectors from the point to each vertex
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         dx[k] = DW'(vx_ff[k]) - DW'(px_ff);
         dy[k] = DW'(vy_ff[k]) - DW'(py_ff);
      end
      // first triangle closes on v3 in quadrangle mode, on v2 otherwise
      t1_cx = (op1_ff == OP_QUADRANGLE) ? dx[3] : dx[2];
      t1_cy = (op1_ff == OP_QUADRANGLE) ? dy[3] : dy[2];
   end

   piq_tri_products #(.COORD_BITS(COORD_BITS)) u_prod_t1 (
      .clock   (clock),
      .load    (free2 && v1_ff),
      .ax      (dx[0]),
      .ay      (dy[0]),
      .bx      (dx[1]),
      .by      (dy[1]),
      .cx      (t1_cx),
      .cy      (t1_cy),
      .p_ab_xy (t1_ab_xy),
      .p_ab_yx (t1_ab_yx),
      .p_bc_xy (t1_bc_xy),
      .p_bc_yx (t1_bc_yx),
      .p_ca_xy (t1_ca_xy),
      .p_ca_yx (t1_ca_yx),
      .flags_a (t1_fa),
      .flags_b (t1_fb),
      .flags_c (t1_fc)
   );

   piq_tri_products #(.COORD_BITS(COORD_BITS)) u_prod_t2 (
      .clock   (clock),
      .load    (free2 && v1_ff),
      .ax      (dx[1]),
      .ay      (dy[1]),
      .bx      (dx[2]),
      .by      (dy[2]),
      .cx      (dx[3]),
      .cy      (dy[3]),
      .p_ab_xy (t2_ab_xy),
      .p_ab_yx (t2_ab_yx),
      .p_bc_xy (t2_bc_xy),
      .p_bc_yx (t2_bc_yx),
      .p_ca_xy (t2_ca_xy),
      .p_ca_yx (t2_ca_yx),
      .flags_a (t2_fa),
      .flags_b (t2_fb),
      .flags_c (t2_fc)
   );

   always_ff @(posedge clock) begin
      if (free2 && v1_ff) begin
         op2_ff <= op1_ff;
      end
   end

   piq_tri_decide #(.COORD_BITS(COORD_BITS)) u_dec_t1 (
      .p_ab_xy (t1_ab_xy),
      .p_ab_yx (t1_ab_yx),
      .p_bc_xy (t1_bc_xy),
      .p_bc_yx (t1_bc_yx),
      .p_ca_xy (t1_ca_xy),
      .p_ca_yx (t1_ca_yx),
      .flags_a (t1_fa),
      .flags_b (t1_fb),
      .flags_c (t1_fc),
      .in_tri  (t1_inside)
   );

   piq_tri_decide #(.COORD_BITS(COORD_BITS)) u_dec_t2 (
      .p_ab_xy (t2_ab_xy),
      .p_ab_yx (t2_ab_yx),
      .p_bc_xy (t2_bc_xy),
      .p_bc_yx (t2_bc_yx),
      .p_ca_xy (t2_ca_xy),
      .p_ca_yx (t2_ca_yx),
      .flags_a (t2_fa),
      .flags_b (t2_fb),
      .flags_c (t2_fc),
      .in_tri  (t2_inside)
   );

   // result register; second triangle only counts in quadrangle mode
   assign res_in = t1_inside | ((op2_ff == OP_QUADRANGLE) & t2_inside);

   always_ff @(posedge clock) begin
      if (free3 && v2_ff) begin
         res_ff <= res_in;
      end
   end
endmodule
`default_nettype wire

/* src/piq_checker.sv */
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the query core.
module piq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_inside_res
);
   // a stalled result item stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_inside_res))
   // the pipeline never blocks the query side while the result side drains
   `ASSERT_IMPLY(a_ready_flow, clock, reset, rsp_ready, req_ready)
   // reset empties the pipeline
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
endmodule

bind point_in_quadrangle_test_core piq_checker u_piq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_inside_res (rsp.inside_res)
);
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

// Checks point_in_quadrangle_test_core against an integer point-in-shape
// predictor. Queries go in through a valid/ready channel with random gaps,
// results come back through a channel with random stalls, and each inside
// bit is compared with the oldest pending prediction.
module testbench;
   import piq_pkg::*;

   localparam int COORD_BITS  = piq_pkg::COORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   // geometry families for random queries
   typedef enum int {
      SHAPE_WIDE,
      SHAPE_CLUSTER,
      SHAPE_TOUCH,
      SHAPE_INNER,
      SHAPE_LINE,
      SHAPE_CORNER
   } shape_type;

   typedef struct packed {
      logic                         op;
      logic signed [COORD_BITS-1:0] vx0;
      logic signed [COORD_BITS-1:0] vy0;
      logic signed [COORD_BITS-1:0] vx1;
      logic signed [COORD_BITS-1:0] vy1;
      logic signed [COORD_BITS-1:0] vx2;
      logic signed [COORD_BITS-1:0] vy2;
      logic signed [COORD_BITS-1:0] vx3;
      logic signed [COORD_BITS-1:0] vy3;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } piq_query_type;

   typedef struct packed {
      piq_query_type query;
      logic          want_in;
   } pending_inside_type;

   logic clock;
   logic reset;

   piq_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   piq_rsp_if rsp_ch ();

   point_in_quadrangle_test_core #(.COORD_BITS(COORD_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   pending_inside_type pending_inside_q[$];

   int error_count    = 0;
   int cycle_count    = 0;
   int gap_max        = 0;
   int stall_max      = 0;
   int rsp_hold       = 0;
   int triangle_count = 0;
   int quad_count     = 0;
   int inside_count   = 0;
   int outside_count  = 0;

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_inside_q.size());
         $display("testbench failed");
         $finish;
      end
   end

   task automatic report_error(string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // triangle (a, b, c) test for point p, exact integer arithmetic
   function automatic logic triangle_contains(longint ax, longint ay, longint bx,
                                              longint by, longint cx, longint cy,
                                              longint px, longint py);
      longint dx[3];
      longint dy[3];
      longint t1;
      longint t2;
      int     n;
      dx[0] = ax - px; dy[0] = ay - py;
      dx[1] = bx - px; dy[1] = by - py;
      dx[2] = cx - px; dy[2] = cy - py;
      // first zero cross product along the edges decides
      for (int k = 0; k < 3; k++) begin
         n = (k + 1) % 3;
         if (dx[k] * dy[n] - dy[k] * dx[n] == 0)
            return !((dx[k] * dx[n] > 0) || (dy[k] * dy[n] > 0));
      end
      t1 = dy[0] * dx[2] - dy[2] * dx[0];
      t2 = dy[0] * dx[1] - dy[1] * dx[0];
      if (int'(t1 > 0) + int'(t2 > 0) != 1)
         return 1'b0;
      t1 = dy[1] * dx[0] - dy[0] * dx[1];
      t2 = dy[1] * dx[2] - dy[2] * dx[1];
      if (int'(t1 > 0) + int'(t2 > 0) != 1)
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic predict_inside(piq_query_type q);
      longint x0, y0, x1, y1, x2, y2, x3, y3, px, py;
      x0 = longint'(q.vx0); y0 = longint'(q.vy0);
      x1 = longint'(q.vx1); y1 = longint'(q.vy1);
      x2 = longint'(q.vx2); y2 = longint'(q.vy2);
      x3 = longint'(q.vx3); y3 = longint'(q.vy3);
      px = longint'(q.point_x); py = longint'(q.point_y);
      if (q.op == OP_TRIANGLE)
         return triangle_contains(x0, y0, x1, y1, x2, y2, px, py);
      return triangle_contains(x0, y0, x1, y1, x3, y3, px, py) ||
             triangle_contains(x1, y1, x2, y2, x3, y3, px, py);
   endfunction

   // ---------------------------------------------------------------
   // query construction
   // ---------------------------------------------------------------

   function automatic piq_query_type build_query(logic op, int x0, int y0, int x1, int y1,
                                                 int x2, int y2, int x3, int y3,
                                                 int px, int py);
      piq_query_type q;
      q.op      = op;
      q.vx0     = COORD_BITS'(x0); q.vy0 = COORD_BITS'(y0);
      q.vx1     = COORD_BITS'(x1); q.vy1 = COORD_BITS'(y1);
      q.vx2     = COORD_BITS'(x2); q.vy2 = COORD_BITS'(y2);
      q.vx3     = COORD_BITS'(x3); q.vy3 = COORD_BITS'(y3);
      q.point_x = COORD_BITS'(px);
      q.point_y = COORD_BITS'(py);
      return q;
   endfunction

   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // values at and next to the ends of the coordinate range, and around zero
   function automatic int corner_coord();
      case ($urandom_range(0, 6))
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   function automatic shape_type pick_shape();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 15) return SHAPE_WIDE;
      if (r < 40) return SHAPE_CLUSTER;
      if (r < 60) return SHAPE_TOUCH;
      if (r < 78) return SHAPE_INNER;
      if (r < 92) return SHAPE_LINE;
      return SHAPE_CORNER;
   endfunction

   function automatic piq_query_type make_query(logic op, shape_type shape);
      int xs[4];
      int ys[4];
      int px;
      int py;
      int bx;
      int by;
      int span;
      int dx;
      int dy;
      int a;
      int pick;
      bx   = int'($urandom_range(0, 64000)) - 32000;
      by   = int'($urandom_range(0, 64000)) - 32000;
      span = int'($urandom_range(1, 40));
      px   = bx;
      py   = by;
      case (shape)
         SHAPE_WIDE: begin
            for (int k = 0; k < 4; k++) begin
               xs[k] = int'($urandom);
               ys[k] = int'($urandom);
            end
            px = int'($urandom);
            py = int'($urandom);
         end
         SHAPE_CLUSTER: begin
            for (int k = 0; k < 4; k++) begin
               xs[k] = bx + jitter(span);
               ys[k] = by + jitter(span);
            end
            px = bx + jitter(span);
            py = by + jitter(span);
         end
         SHAPE_TOUCH: begin
            // even offsets so edge midpoints are exact lattice points
            for (int k = 0; k < 4; k++) begin
               xs[k] = bx + 2 * jitter(span);
               ys[k] = by + 2 * jitter(span);
            end
            pick = int'($urandom_range(0, 7));
            if (pick < 4) begin
               px = xs[pick];
               py = ys[pick];
            end else begin
               a  = pick - 4;
               px = (xs[a] + xs[(a + 1) % 4]) / 2;
               py = (ys[a] + ys[(a + 1) % 4]) / 2;
            end
         end
         SHAPE_INNER: begin
            span = int'($urandom_range(1, 700));
            for (int k = 0; k < 4; k++) begin
               xs[k] = bx + jitter(span);
               ys[k] = by + jitter(span);
            end
            if (op == OP_TRIANGLE) begin
               px = (xs[0] + xs[1] + xs[2]) / 3 + jitter(1);
               py = (ys[0] + ys[1] + ys[2]) / 3 + jitter(1);
            end else begin
               px = (xs[0] + xs[1] + xs[2] + xs[3]) / 4 + jitter(1);
               py = (ys[0] + ys[1] + ys[2] + ys[3]) / 4 + jitter(1);
            end
         end
         SHAPE_LINE: begin
            // collinear vertices, point on the line or nearby
            dx = jitter(8);
            dy = jitter(8);
            for (int k = 0; k < 4; k++) begin
               a     = jitter(3);
               xs[k] = bx + dx * a;
               ys[k] = by + dy * a;
            end
            if ($urandom_range(0, 1)) begin
               a  = jitter(4);
               px = bx + dx * a;
               py = by + dy * a;
            end else begin
               px = bx + jitter(20);
               py = by + jitter(20);
            end
         end
         default: begin
            for (int k = 0; k < 4; k++) begin
               xs[k] = corner_coord();
               ys[k] = corner_coord();
            end
            px = corner_coord();
            py = corner_coord();
         end
      endcase
      return build_query(op, xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3],
                         px, py);
   endfunction

   // ---------------------------------------------------------------
   // query side: one item per call, called at a falling edge
   // ---------------------------------------------------------------

   task automatic send_query(piq_query_type q);
      int gap;
      pending_inside_type entry;
      gap = (gap_max > 0) ? int'($urandom_range(0, gap_max)) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.op      = q.op;
      req_ch.vx0     = q.vx0; req_ch.vy0 = q.vy0;
      req_ch.vx1     = q.vx1; req_ch.vy1 = q.vy1;
      req_ch.vx2     = q.vx2; req_ch.vy2 = q.vy2;
      req_ch.vx3     = q.vx3; req_ch.vy3 = q.vy3;
      req_ch.point_x = q.point_x;
      req_ch.point_y = q.point_y;
      req_ch.valid   = 1'b1;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      entry.query   = q;
      entry.want_in = predict_inside(q);
      pending_inside_q.push_back(entry);
      if (q.op == OP_TRIANGLE) triangle_count++;
      else quad_count++;
      @(negedge clock);
   endtask

   // stop offering items and wait until every result is back
   task automatic wait_for_results();
      req_ch.valid = 1'b0;
      while (pending_inside_q.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls, check at the rising edge
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      pending_inside_type entry;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_inside_q.size() == 0) begin
            report_error($sformatf("result %b with no query pending", rsp_ch.inside_res));
         end else begin
            entry = pending_inside_q.pop_front();
            if (rsp_ch.inside_res !== entry.want_in)
               report_error($sformatf(
                  "op=%0d v=(%0d,%0d)(%0d,%0d)(%0d,%0d)(%0d,%0d) p=(%0d,%0d): inside %b, want %b",
                  entry.query.op, entry.query.vx0, entry.query.vy0, entry.query.vx1,
                  entry.query.vy1, entry.query.vx2, entry.query.vy2, entry.query.vx3,
                  entry.query.vy3, entry.query.point_x, entry.query.point_y,
                  rsp_ch.inside_res, entry.want_in));
            if (entry.want_in) inside_count++;
            else outside_count++;
         end
         rsp_hold = (stall_max > 0) ? int'($urandom_range(0, stall_max)) : 0;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // hand-picked geometry: edges, vertices, degenerate shapes, range ends
   task automatic test_directed_cases();
      gap_max   = 3;
      stall_max = 3;
      // right triangle: inside, outside, vertex, on edge, on edge line beyond
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 10, 10));
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 80, 80));
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 100, 0));
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 50, 0));
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 200, 0));
      send_query(build_query(OP_TRIANGLE, 0, 0, 100, 0, 0, 100, 0, 0, 50, 50));
      // clockwise winding
      send_query(build_query(OP_TRIANGLE, 0, 0, 0, 100, 100, 0, 0, 0, 10, 10));
      // collinear vertices, point on and off the line
      send_query(build_query(OP_TRIANGLE, 0, 0, 10, 10, 20, 20, 0, 0, 5, 5));
      send_query(build_query(OP_TRIANGLE, 0, 0, 10, 10, 20, 20, 0, 0, 30, 30));
      send_query(build_query(OP_TRIANGLE, 0, 0, 10, 10, 20, 20, 0, 0, 5, 6));
      // all points coincide
      send_query(build_query(OP_TRIANGLE, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7));
      // range ends, with vertex 3 as noise in triangle mode
      send_query(build_query(OP_TRIANGLE, -32768, -32768, 32767, -32768, -32768, 32767,
                             -1, 32767, 0, 0));
      send_query(build_query(OP_TRIANGLE, -32768, -32768, 32767, -32768, -32768, 32767,
                             32767, -1, -32768, -32768));
      send_query(build_query(OP_TRIANGLE, -32768, -32768, 32767, -32768, -32768, 32767,
                             0, 0, 32767, 32767));
      send_query(build_query(OP_TRIANGLE, 32767, 32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767, 32767));
      send_query(build_query(OP_TRIANGLE, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768));
      // square: inside, on the shared diagonal, outside, on a vertex
      send_query(build_query(OP_QUADRANGLE, 0, 0, 100, 0, 100, 100, 0, 100, 70, 20));
      send_query(build_query(OP_QUADRANGLE, 0, 0, 100, 0, 100, 100, 0, 100, 50, 50));
      send_query(build_query(OP_QUADRANGLE, 0, 0, 100, 0, 100, 100, 0, 100, 150, 50));
      send_query(build_query(OP_QUADRANGLE, 0, 0, 100, 0, 100, 100, 0, 100, 100, 100));
      // concave quadrangle, point in the notch
      send_query(build_query(OP_QUADRANGLE, 0, 0, 100, 0, 20, 20, 0, 100, 50, 50));
      // quadrangle over the whole range
      send_query(build_query(OP_QUADRANGLE, -32768, -32768, 32767, -32768, 32767, 32767,
                             -32768, 32767, -1, -1));
      send_query(build_query(OP_QUADRANGLE, -32768, -32768, 32767, -32768, 32767, 32767,
                             -32768, 32767, 32767, -32768));
   endtask

   task automatic test_random_triangles(int count);
      gap_max   = 15;
      stall_max = 15;
      repeat (count) send_query(make_query(OP_TRIANGLE, pick_shape()));
   endtask

   task automatic test_random_quadrangles(int count);
      gap_max   = 15;
      stall_max = 15;
      repeat (count) send_query(make_query(OP_QUADRANGLE, pick_shape()));
   endtask

   // back to back on both sides
   task automatic test_full_rate(int count);
      gap_max   = 0;
      stall_max = 0;
      repeat (count) send_query(make_query(logic'($urandom_range(0, 1)), pick_shape()));
   endtask

   // sender holds off until the pipeline has drained, several times
   task automatic test_drain_pauses(int bursts);
      stall_max = 6;
      for (int b = 0; b < bursts; b++) begin
         gap_max = (b % 2 == 0) ? 0 : 4;
         repeat (int'($urandom_range(3, 12)))
            send_query(make_query(logic'($urandom_range(0, 1)), pick_shape()));
         wait_for_results();
         repeat (4) @(negedge clock);
      end
   endtask

   // mixed ops, idling switched on and off per stretch
   task automatic test_mixed_stretches(int stretches);
      for (int s = 0; s < stretches; s++) begin
         gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 15;
         stall_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
         repeat (int'($urandom_range(10, 40)))
            send_query(make_query(logic'($urandom_range(0, 1)), pick_shape()));
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_TRIANGLE;
      req_ch.vx0     = '0; req_ch.vy0 = '0;
      req_ch.vx1     = '0; req_ch.vy1 = '0;
      req_ch.vx2     = '0; req_ch.vy2 = '0;
      req_ch.vx3     = '0; req_ch.vy3 = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      rsp_ch.ready   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_triangles(350);
      test_drain_pauses(6);
      test_random_quadrangles(350);
      test_full_rate(200);
      test_mixed_stretches(16);

      wait_for_results();
      repeat (10) @(posedge clock);

      $display("checked %0d triangle and %0d quadrangle queries (%0d inside, %0d outside)",
               triangle_count, quad_count, inside_count, outside_count);
      $display("directed edge and vertex cases, random geometry, full-rate and drained runs");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench failed");
      end
      $finish;
   end

endmodule
